>>> design/snbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snbg_pkg
// Shared types and constants for the shock node boundary geometry pipeline.
// ----------------------------------------------------------------------------
package snbg_pkg;

  localparam int UNIT_W   = 16;
  localparam int SINE_LAT = 8;   // register stages in the sine pipeline

  typedef logic signed [UNIT_W-1:0] unit_t;

  // odd polynomial constants for sin(pi/2 * x), Q30
  localparam logic [30:0] POLY_K0 = 31'd1686629713;
  localparam logic [30:0] POLY_K1 = 31'd693598668;
  localparam logic [30:0] POLY_K2 = 31'd85569305;
  localparam logic [30:0] POLY_K3 = 31'd5026995;
  localparam logic [30:0] POLY_K4 = 31'd172272;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam unit_t       UNIT_MAX = 16'sd32767;

endpackage
`default_nettype wire

>>> design/shock_node_boundary_geometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shock_node_boundary_geometry
// Boundary points, chord midpoint and boundary tangents of one shock node.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready carries one node request: node_x,
//    node_y, tangent_angle, half_angle, node_radius.
//  - Output channel out_valid/out_ready carries the ten result fields.
//  - One request is accepted every cycle while the receiver takes
//    results. The rate is set by the 12-stage pipeline, whose longest
//    path is one 31x31 multiply in the polynomial sine stages.
//  - Seven sine pipelines run in parallel (psi+phi, psi-phi, psi and their
//    quarter-turn shifts, plus phi shifted); tangents reuse them by symmetry.
//  - Stage 9 scales by radius, stage 10 forms boundary sums and the
//    chord-distance products, stage 11 forms the midpoint sums.
//  - Reset clears all stage valid bits; nothing is in flight afterwards.
//  - When out_ready is low with a result waiting, every stage holds and
//    in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module shock_node_boundary_geometry
  import snbg_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] node_x,
  input  wire logic signed [COORD_BITS-1:0] node_y,
  input  wire logic [ANGLE_BITS-1:0]        tangent_angle,
  input  wire logic [ANGLE_BITS-1:0]        half_angle,
  input  wire logic [COORD_BITS-2:0]        node_radius,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      left_x,
  output logic signed [COORD_BITS-1:0]      left_y,
  output logic signed [COORD_BITS-1:0]      right_x,
  output logic signed [COORD_BITS-1:0]      right_y,
  output logic signed [COORD_BITS-1:0]      mid_x,
  output logic signed [COORD_BITS-1:0]      mid_y,
  output unit_t                             left_tan_x,
  output unit_t                             left_tan_y,
  output unit_t                             right_tan_x,
  output unit_t                             right_tan_y
);

  localparam int LAT = SINE_LAT + 4;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic coord_t sat_coord(input logic signed [COORD_BITS:0] v);
    logic signed [COORD_BITS:0] hi;
    logic signed [COORD_BITS:0] lo;
    hi = {2'b00, {(COORD_BITS-1){1'b1}}};
    lo = -hi - 1;
    if (v > hi) return hi[COORD_BITS-1:0];
    if (v < lo) return lo[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  // global advance: a stage moves whenever the output slot frees up
  logic en;
  logic [LAT-1:0] vld;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 0 input register plus coordinate delay line to the sine outputs
  coord_t          px_d [0:SINE_LAT];
  coord_t          py_d [0:SINE_LAT];
  coord_t          r_d  [0:SINE_LAT];
  logic [ANGLE_BITS-1:0] psi0, phi0;

  always_ff @(posedge clk) begin
    if (en) begin
      px_d[0] <= node_x;
      py_d[0] <= node_y;
      r_d[0]  <= coord_t'({1'b0, node_radius});
      psi0    <= tangent_angle;
      phi0    <= half_angle;
      for (int i = 1; i <= SINE_LAT; i++) begin
        px_d[i] <= px_d[i-1];
        py_d[i] <= py_d[i-1];
        r_d[i]  <= r_d[i-1];
      end
    end
  end

  logic [ANGLE_BITS-1:0] al, ar;
  assign al = psi0 + phi0;
  assign ar = psi0 - phi0;

  unit_t cos_al, sin_al, cos_ar, sin_ar, cos_phi, cos_psi, sin_psi;

  snbg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_al (
    .clk(clk), .en(en), .angle(al + QUARTER), .value(cos_al));
  snbg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_al (
    .clk(clk), .en(en), .angle(al), .value(sin_al));
  snbg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ar (
    .clk(clk), .en(en), .angle(ar + QUARTER), .value(cos_ar));
  snbg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ar (
    .clk(clk), .en(en), .angle(ar), .value(sin_ar));
  snbg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_phi (
    .clk(clk), .en(en), .angle(phi0 + QUARTER), .value(cos_phi));
  snbg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_psi (
    .clk(clk), .en(en), .angle(psi0 + QUARTER), .value(cos_psi));
  snbg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_psi (
    .clk(clk), .en(en), .angle(psi0), .value(sin_psi));

  // stage 9: radius scaling
  coord_t off_lx, off_ly, off_rx, off_ry, chord_len;

  snbg_scale #(.COORD_BITS(COORD_BITS)) u_sc_lx (
    .clk(clk), .en(en), .len(r_d[SINE_LAT]), .comp(cos_al), .scaled(off_lx));
  snbg_scale #(.COORD_BITS(COORD_BITS)) u_sc_ly (
    .clk(clk), .en(en), .len(r_d[SINE_LAT]), .comp(sin_al), .scaled(off_ly));
  snbg_scale #(.COORD_BITS(COORD_BITS)) u_sc_rx (
    .clk(clk), .en(en), .len(r_d[SINE_LAT]), .comp(cos_ar), .scaled(off_rx));
  snbg_scale #(.COORD_BITS(COORD_BITS)) u_sc_ry (
    .clk(clk), .en(en), .len(r_d[SINE_LAT]), .comp(sin_ar), .scaled(off_ry));
  snbg_scale #(.COORD_BITS(COORD_BITS)) u_sc_d (
    .clk(clk), .en(en), .len(r_d[SINE_LAT]), .comp(cos_phi), .scaled(chord_len));

  coord_t px9, py9, px10, py10;
  unit_t  cpsi9, spsi9;
  unit_t  ltx9, lty9, rtx9, rty9, ltx10, lty10, rtx10, rty10;
  coord_t lx10, ly10, rx10, ry10;

  // tangents by symmetry: cos,sin(al-q) = sin,-cos(al); cos,sin(ar+q) = -sin,cos(ar)
  always_ff @(posedge clk) begin
    if (en) begin
      px9   <= px_d[SINE_LAT];
      py9   <= py_d[SINE_LAT];
      cpsi9 <= cos_psi;
      spsi9 <= sin_psi;
      ltx9  <= sin_al;
      lty9  <= -cos_al;
      rtx9  <= -sin_ar;
      rty9  <= cos_ar;
    end
  end

  // stage 10: boundary sums and chord distance products
  coord_t off_mx, off_my;

  snbg_scale #(.COORD_BITS(COORD_BITS)) u_sc_mx (
    .clk(clk), .en(en), .len(chord_len), .comp(cpsi9), .scaled(off_mx));
  snbg_scale #(.COORD_BITS(COORD_BITS)) u_sc_my (
    .clk(clk), .en(en), .len(chord_len), .comp(spsi9), .scaled(off_my));

  always_ff @(posedge clk) begin
    if (en) begin
      lx10  <= sat_coord((COORD_BITS+1)'(px9) + (COORD_BITS+1)'(off_lx));
      ly10  <= sat_coord((COORD_BITS+1)'(py9) + (COORD_BITS+1)'(off_ly));
      rx10  <= sat_coord((COORD_BITS+1)'(px9) + (COORD_BITS+1)'(off_rx));
      ry10  <= sat_coord((COORD_BITS+1)'(py9) + (COORD_BITS+1)'(off_ry));
      px10  <= px9;
      py10  <= py9;
      ltx10 <= ltx9;
      lty10 <= lty9;
      rtx10 <= rtx9;
      rty10 <= rty9;
    end
  end

  // stage 11: midpoint sums, output register
  always_ff @(posedge clk) begin
    if (en) begin
      mid_x       <= sat_coord((COORD_BITS+1)'(px10) + (COORD_BITS+1)'(off_mx));
      mid_y       <= sat_coord((COORD_BITS+1)'(py10) + (COORD_BITS+1)'(off_my));
      left_x      <= lx10;
      left_y      <= ly10;
      right_x     <= rx10;
      right_y     <= ry10;
      left_tan_x  <= ltx10;
      left_tan_y  <= lty10;
      right_tan_x <= rtx10;
      right_tan_y <= rty10;
    end
  end

endmodule
`default_nettype wire

>>> design/snbg_sine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snbg_sine
// Pipelined Q15 sine of a binary angle, at most one multiply per stage, 8 stages.
// ----------------------------------------------------------------------------
module snbg_sine
  import snbg_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output unit_t                      value
);

  localparam int REM_BITS = ANGLE_BITS - 2;
  localparam int X_SHIFT  = 30 - REM_BITS;

  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = {31'd0, a} * {31'd0, b};
    return p[60:30];
  endfunction

  logic [30:0] xa, xb, xc, xd, xe, xf;
  logic [1:0]  qa, qb, qc, qd, qe, qf, qg;
  logic [30:0] x2b, x2c, x2d, x2e;
  logic [30:0] tc, td, te, tf;
  logic [30:0] sg;
  logic [30:0] x_in;
  logic [31:0] rnd;
  logic [16:0] mag;
  unit_t       mag_sat;

  always_comb begin
    x_in = 31'({angle[REM_BITS-1:0]}) << X_SHIFT;
    if (angle[REM_BITS]) x_in = ONE_Q30 - x_in;
  end

  assign rnd     = {1'b0, sg} + 32'h0000_4000;
  assign mag     = rnd[31:15];
  assign mag_sat = (mag > 17'd32767) ? UNIT_MAX : unit_t'(mag[15:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      xa  <= x_in;
      qa  <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
      x2b <= mul_q30(xa, xa);
      xb  <= xa;  qb <= qa;
      tc  <= POLY_K3 - mul_q30(x2b, POLY_K4);
      x2c <= x2b; xc <= xb; qc <= qb;
      td  <= POLY_K2 - mul_q30(x2c, tc);
      x2d <= x2c; xd <= xc; qd <= qc;
      te  <= POLY_K1 - mul_q30(x2d, td);
      x2e <= x2d; xe <= xd; qe <= qd;
      tf  <= POLY_K0 - mul_q30(x2e, te);
      xf  <= xe;  qf <= qe;
      sg  <= mul_q30(xf, tf);
      qg  <= qf;
      value <= qg[1] ? -mag_sat : mag_sat;
    end
  end

endmodule
`default_nettype wire

>>> design/snbg_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snbg_scale
// Registered length times Q15 component, floored by 15 bits.
// ----------------------------------------------------------------------------
module snbg_scale
  import snbg_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [COORD_BITS-1:0] len,
  input  wire unit_t                        comp,
  output logic signed [COORD_BITS-1:0]      scaled
);

  logic signed [COORD_BITS+UNIT_W-1:0] prod;
  logic signed [COORD_BITS+UNIT_W-1:0] shifted;

  assign prod    = len * comp;
  assign shifted = prod >>> 15;

  always_ff @(posedge clk) begin
    if (en) scaled <= shifted[COORD_BITS-1:0];
  end

endmodule
`default_nettype wire

>>> design/snbg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snbg_checker
// Port-level assertions for the shock node boundary geometry block.
// ----------------------------------------------------------------------------
module snbg_checker
  import snbg_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  in_ready,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire unit_t left_tan_x,
  input wire unit_t left_tan_y,
  input wire unit_t right_tan_x,
  input wire unit_t right_tan_y
);

  // a waiting result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // backpressure only from a stalled output slot
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready out of step with output slot");

  // unit components never reach the negative full scale
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_tan_x != -16'sd32768) && (left_tan_y != -16'sd32768)
               && (right_tan_x != -16'sd32768) && (right_tan_y != -16'sd32768))
    else $error("unit component out of range");

endmodule

bind shock_node_boundary_geometry snbg_checker u_snbg_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .left_tan_x(left_tan_x), .left_tan_y(left_tan_y),
  .right_tan_x(right_tan_x), .right_tan_y(right_tan_y));
`default_nettype wire

>>> sim/snbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snbg_scoreboard
// Watches both channels of the boundary geometry block, predicts each
// result from the accepted node request and compares it field by field.
// ----------------------------------------------------------------------------
module snbg_scoreboard
  import snbg_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic signed [COORD_BITS-1:0] node_x,
  input  wire logic signed [COORD_BITS-1:0] node_y,
  input  wire logic [ANGLE_BITS-1:0]        tangent_angle,
  input  wire logic [ANGLE_BITS-1:0]        half_angle,
  input  wire logic [COORD_BITS-2:0]        node_radius,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic signed [COORD_BITS-1:0] left_x,
  input  wire logic signed [COORD_BITS-1:0] left_y,
  input  wire logic signed [COORD_BITS-1:0] right_x,
  input  wire logic signed [COORD_BITS-1:0] right_y,
  input  wire logic signed [COORD_BITS-1:0] mid_x,
  input  wire logic signed [COORD_BITS-1:0] mid_y,
  input  wire unit_t                        left_tan_x,
  input  wire unit_t                        left_tan_y,
  input  wire unit_t                        right_tan_x,
  input  wire unit_t                        right_tan_y,
  output int                                fail_count,
  output int                                pending
);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    coord_t lx, ly, rx, ry, mx, my;
    unit_t  ltx, lty, rtx, rty;
  } geom_t;

  localparam angle_t QUARTER = angle_t'(1) << (ANGLE_BITS - 2);

  geom_t geom_q[$];

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint sin15(angle_t a);
    longint unsigned x, x2, t, m;
    logic [1:0] quad;
    quad = a[ANGLE_BITS-1 -: 2];
    x = longint'(a[ANGLE_BITS-3:0]) << (30 - (ANGLE_BITS - 2));
    if (quad[0]) x = (64'd1 << 30) - x;
    x2 = qmul(x, x);
    t = POLY_K4;
    t = POLY_K3 - qmul(x2, t);
    t = POLY_K2 - qmul(x2, t);
    t = POLY_K1 - qmul(x2, t);
    t = POLY_K0 - qmul(x2, t);
    m = (qmul(x, t) + (64'd1 << 14)) >> 15;
    if (m > 32767) m = 32767;
    return quad[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint cos15(angle_t a);
    return sin15(angle_t'(a + QUARTER));
  endfunction

  // arithmetic shift floors, matching the truncation toward minus infinity
  function automatic longint scale15(longint a, longint b);
    return (a * b) >>> 15;
  endfunction

  function automatic coord_t clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return coord_t'(v);
  endfunction

  function automatic geom_t boundary_geometry(coord_t px, coord_t py, angle_t psi,
                                              angle_t phi, longint r);
    geom_t g;
    angle_t al, ar;
    longint d;
    al = psi + phi;
    ar = psi - phi;
    g.lx = clamp(px + scale15(r, cos15(al)));
    g.ly = clamp(py + scale15(r, sin15(al)));
    g.rx = clamp(px + scale15(r, cos15(ar)));
    g.ry = clamp(py + scale15(r, sin15(ar)));
    d = scale15(r, cos15(phi));
    g.mx = clamp(px + scale15(d, cos15(psi)));
    g.my = clamp(py + scale15(d, sin15(psi)));
    g.ltx = unit_t'(cos15(angle_t'(al - QUARTER)));
    g.lty = unit_t'(sin15(angle_t'(al - QUARTER)));
    g.rtx = unit_t'(cos15(angle_t'(ar + QUARTER)));
    g.rty = unit_t'(sin15(angle_t'(ar + QUARTER)));
    return g;
  endfunction

  initial fail_count = 0;
  assign pending = geom_q.size();

  always @(posedge clk) begin
    geom_t want, got;
    if (!rst && in_valid && in_ready)
      geom_q.push_back(boundary_geometry(node_x, node_y, tangent_angle, half_angle,
                                         longint'(node_radius)));
    if (!rst && out_valid && out_ready) begin
      got = '{left_x, left_y, right_x, right_y, mid_x, mid_y,
              left_tan_x, left_tan_y, right_tan_x, right_tan_y};
      if (geom_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = geom_q.pop_front();
        if (want != got) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch lx %0d/%0d ly %0d/%0d rx %0d/%0d ry %0d/%0d",
                     want.lx, got.lx, want.ly, got.ly, want.rx, got.rx,
                     want.ry, got.ry);
            $display("  mx %0d/%0d my %0d/%0d lt %0d,%0d/%0d,%0d rt %0d,%0d/%0d,%0d",
                     want.mx, got.mx, want.my, got.my, want.ltx, want.lty,
                     got.ltx, got.lty, want.rtx, want.rty, got.rtx, got.rty);
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_shock_node_boundary_geometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shock_node_boundary_geometry
// Drives node requests through the boundary geometry block under several
// idling phases; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_shock_node_boundary_geometry;
  import snbg_pkg::*;

  localparam int CB = 24;
  localparam int AB = 16;
  localparam int DRAIN = 40;   // pipeline is 12 deep; plenty of margin

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic in_ready, out_valid;
  logic signed [CB-1:0] node_x = '0, node_y = '0;
  logic [AB-1:0] tangent_angle = '0, half_angle = '0;
  logic [CB-2:0] node_radius = '0;
  logic signed [CB-1:0] left_x, left_y, right_x, right_y, mid_x, mid_y;
  unit_t left_tan_x, left_tan_y, right_tan_x, right_tan_y;
  int fail_count, pending;

  // idle percentages for the sender and the receiver, changed per phase
  int send_idle = 0, recv_stall = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  shock_node_boundary_geometry #(.COORD_BITS(CB), .ANGLE_BITS(AB)) u_dut (.*);

  snbg_scoreboard #(.COORD_BITS(CB), .ANGLE_BITS(AB)) u_chk (.*);

  // receiver: out_ready decided fresh every edge
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  // place one request on the input channel and hold it until accepted;
  // valid drops only while the sender idles
  task automatic send_node(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                           logic [AB-1:0] psi, logic [AB-1:0] phi,
                           logic [CB-2:0] r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    node_x        <= px;
    node_y        <= py;
    tangent_angle <= psi;
    half_angle    <= phi;
    node_radius   <= r;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // random node: mostly moderate coordinates, sometimes full-range extremes
  task automatic send_random();
    logic signed [CB-1:0] px, py;
    logic [CB-2:0] r;
    int pick;
    pick = $urandom_range(9);
    px = CB'($urandom);
    py = CB'($urandom);
    r  = (CB-1)'($urandom);
    if (pick < 6) begin
      // shifted down so most sums stay in range
      px = px >>> $urandom_range(12);
      py = py >>> $urandom_range(12);
      r  = r >> $urandom_range(12);
    end else if (pick == 6) begin
      r = '1;
    end
    send_node(px, py, AB'($urandom), AB'($urandom), r);
  endtask

  initial begin
    logic signed [CB-1:0] cmax, cmin;
    cmax = {1'b0, {(CB-1){1'b1}}};
    cmin = {1'b1, {(CB-1){1'b0}}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero radius, axis angles, half turn and beyond, saturation
    send_node('0, '0, '0, '0, '0);
    send_node(cmax, cmax, 16'h0000, 16'h0000, '1);
    send_node(cmin, cmin, 16'h8000, 16'h0000, '1);
    send_node(cmax, cmin, 16'h4000, 16'h4000, '1);
    send_node(cmin, cmax, 16'hC000, 16'h2000, '1);
    send_node('0, '0, 16'hFFFF, 16'hFFFF, '1);
    send_node('0, '0, 16'h2000, 16'h8000, 23'h10000);
    send_node('0, '0, 16'h1234, 16'hA000, 23'h7FFF);
    send_node(24'sd100, -24'sd100, 16'h4000, 16'h0000, 23'd1);
    send_node(cmax, cmax, 16'h0001, 16'h7FFF, '0);
    send_node(cmin, cmin, 16'hBFFF, 16'hC000, 23'h400000);
    send_node(24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA, 23'h2AAAAA);
    send_node(24'hAAAAAA, 24'h555555, 16'hAAAA, 16'h5555, 23'h555555);

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 71) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 71) : 0;
      repeat (200) send_random();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog: worst case ~800 requests * (sender and receiver stalls + latency)
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
design/snbg_pkg.sv
design/snbg_sine.sv
design/snbg_scale.sv
design/shock_node_boundary_geometry.sv
design/snbg_checker.sv
sim/snbg_checker.sv
sim/tb_shock_node_boundary_geometry.sv
